@@ design/bae_pkg.sv @@
`default_nettype none
package bae_pkg;

  // defaults for the top-level parameters
  localparam int CODE_BITS_DEF    = 24;
  localparam int PROB_BITS_DEF    = 16;
  localparam int PENDING_BITS_DEF = 16;

  // fixed field widths of the channels
  localparam int PROB_W   = 16;
  localparam int FOLLOW_W = 16;

  // most runs delivered for one symbol; later ones are dropped
  localparam int MAX_RUNS = 24;

  // depth of the command queue between front and core
  localparam int QUEUE_DEPTH = 2;

  // command classes
  typedef enum logic [1:0] {
    OP_ZERO,
    OP_ONE,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PROB_W-1:0] prob;
  } cmd_t;

endpackage
`default_nettype wire

@@ design/bae_if.sv @@
`default_nettype none
// symbol channel
interface bae_in_if;
  logic                      valid;
  logic                      ready;
  logic                      bit_value;
  logic [bae_pkg::PROB_W-1:0] prob_zero;
  logic                      end_of_stream;

  modport source(output valid, bit_value, prob_zero, end_of_stream, input ready);
  modport sink(input valid, bit_value, prob_zero, end_of_stream, output ready);
endinterface

// run channel
interface bae_out_if;
  logic                        valid;
  logic                        ready;
  logic                        lead_bit;
  logic [bae_pkg::FOLLOW_W-1:0] follow_count;
  logic                        run_last;

  modport source(output valid, lead_bit, follow_count, run_last, input ready);
  modport sink(input valid, lead_bit, follow_count, run_last, output ready);
endinterface
`default_nettype wire

@@ design/bae_front.sv @@
`default_nettype none
module bae_front #(
  parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  bae_in_if.sink             in_ch,
  output logic               push_valid,
  input  wire logic          push_ready,
  output bae_pkg::cmd_t      push_cmd
);

  localparam int MaskBits = (PROB_BITS < bae_pkg::PROB_W) ? PROB_BITS : bae_pkg::PROB_W;
  localparam logic [bae_pkg::PROB_W-1:0] ProbMask =
    bae_pkg::PROB_W'(((bae_pkg::PROB_W+1)'(1) << MaskBits) - (bae_pkg::PROB_W+1)'(1));

  logic          stage_v_r;
  logic          stage_v_nxt;
  bae_pkg::cmd_t stage_cmd_r;
  bae_pkg::cmd_t stage_cmd_nxt;
  bae_pkg::cmd_t cls_cmd;
  logic          in_beat;

  // classify the incoming beat and keep only the used probability bits
  always_comb begin
    if (in_ch.end_of_stream) begin
      cls_cmd.op = bae_pkg::OP_FLUSH;
    end else if (in_ch.bit_value) begin
      cls_cmd.op = bae_pkg::OP_ONE;
    end else begin
      cls_cmd.op = bae_pkg::OP_ZERO;
    end
    cls_cmd.prob = in_ch.prob_zero & ProbMask;
  end

  assign in_ch.ready = !stage_v_r || push_ready;
  assign in_beat     = in_ch.valid && in_ch.ready;

  // one staging register in front of the queue
  always_comb begin
    stage_v_nxt   = stage_v_r;
    stage_cmd_nxt = stage_cmd_r;
    if (in_beat) begin
      stage_v_nxt   = 1'b1;
      stage_cmd_nxt = cls_cmd;
    end else if (push_ready) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
    stage_cmd_r <= stage_cmd_nxt;
  end

  assign push_valid = stage_v_r;
  assign push_cmd   = stage_cmd_r;

endmodule
`default_nettype wire

@@ design/bae_queue.sv @@
`default_nettype none
module bae_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire bae_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output bae_pkg::cmd_t      pop_cmd
);

  localparam int Depth = bae_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  bae_pkg::cmd_t       entry_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [PtrW-1:0]     rd_ptr_nxt;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     count_nxt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ design/bae_core.sv @@
`default_nettype none
module bae_core #(
  parameter int CODE_BITS    = bae_pkg::CODE_BITS_DEF,
  parameter int PROB_BITS    = bae_pkg::PROB_BITS_DEF,
  parameter int PENDING_BITS = bae_pkg::PENDING_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire bae_pkg::cmd_t pop_cmd,
  bae_out_if.source          out_ch
);

  localparam int CB     = CODE_BITS;
  localparam int PW     = bae_pkg::PROB_W;
  localparam int FW     = bae_pkg::FOLLOW_W;
  localparam int ProdW  = CB + 1 + PW;
  localparam int GuardW = $clog2(CB + 2);
  localparam int RunW   = $clog2(bae_pkg::MAX_RUNS + 1);
  localparam logic [CB-1:0] Qtr = {2'b01, {(CB - 2){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_NORM
  } state_t;

  state_t                state_r, state_nxt;
  logic [CB-1:0]         low_r, low_nxt;
  logic [CB-1:0]         high_r, high_nxt;
  logic [PENDING_BITS-1:0] pend_r, pend_nxt;
  logic [ProdW-1:0]      prod_r, prod_nxt;
  logic                  bit_r, bit_nxt;
  logic [GuardW-1:0]     guard_r, guard_nxt;
  logic [RunW-1:0]       runs_r, runs_nxt;
  logic                  held_v_r, held_v_nxt;
  logic                  held_lead_r, held_lead_nxt;
  logic [FW-1:0]         held_cnt_r, held_cnt_nxt;
  logic                  out_v_r, out_v_nxt;
  logic                  out_lead_r, out_lead_nxt;
  logic [FW-1:0]         out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic [CB:0]           range_w;
  logic [ProdW-1:0]      prod_sh;
  logic [CB-1:0]         part;
  logic [PENDING_BITS-1:0] pend_inc;
  logic [FW+PENDING_BITS-1:0] pend_ext;
  logic [FW-1:0]         follow_cur;
  logic [FW+PENDING_BITS-1:0] inc_ext;
  logic [FW-1:0]         follow_inc;
  logic [CB-1:0]         low_q;
  logic [CB-1:0]         high_q;
  logic                  do_emit;
  logic                  do_mid;
  logic                  active;
  logic                  drop;

  // datapath helpers
  assign out_free   = !out_v_r || out_ch.ready;
  assign range_w    = {1'b0, high_r} - {1'b0, low_r} + (CB + 1)'(1);
  assign prod_sh    = prod_r >> PROB_BITS;
  assign part       = prod_sh[CB-1:0];
  assign pend_inc   = (pend_r == '1) ? pend_r : pend_r + PENDING_BITS'(1);
  assign pend_ext   = {{FW{1'b0}}, pend_r};
  assign follow_cur = pend_ext[FW-1:0];
  assign inc_ext    = {{FW{1'b0}}, pend_inc};
  assign follow_inc = inc_ext[FW-1:0];
  assign low_q      = low_r - Qtr;
  assign high_q     = high_r - Qtr;

  // renorm classification: leave a half, or straddle the middle
  assign do_emit = !high_r[CB-1] || low_r[CB-1];
  assign do_mid  = low_r[CB-2] && !high_r[CB-2];
  assign active  = (guard_r <= GuardW'(CB));
  assign drop    = (runs_r >= RunW'(bae_pkg::MAX_RUNS));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    pend_nxt      = pend_r;
    prod_nxt      = prod_r;
    bit_nxt       = bit_r;
    guard_nxt     = guard_r;
    runs_nxt      = runs_r;
    held_v_nxt    = held_v_r;
    held_lead_nxt = held_lead_r;
    held_cnt_nxt  = held_cnt_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_lead_nxt  = out_lead_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    pop_ready     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.op == bae_pkg::OP_FLUSH) begin
            // termination run straight to the output register
            if (out_free) begin
              pop_ready    = 1'b1;
              pend_nxt     = pend_inc;
              out_v_nxt    = 1'b1;
              out_lead_nxt = low_r[CB-1] || low_r[CB-2];
              out_cnt_nxt  = follow_inc;
              out_last_nxt = 1'b1;
            end
          end else begin
            pop_ready = 1'b1;
            bit_nxt   = (pop_cmd.op == bae_pkg::OP_ONE);
            prod_nxt  = {{PW{1'b0}}, range_w} * {{(CB + 1){1'b0}}, pop_cmd.prob};
            state_nxt = S_UPD;
          end
        end
      end

      S_UPD: begin
        // narrow the interval to the chosen sub-range
        if (bit_r) begin
          low_nxt = low_r + part;
        end else begin
          high_nxt = low_r + part;
        end
        guard_nxt = '0;
        runs_nxt  = '0;
        state_nxt = S_NORM;
      end

      S_NORM: begin
        if (active && do_emit) begin
          if (drop || !held_v_r || out_free) begin
            if (!drop) begin
              if (held_v_r) begin
                out_v_nxt    = 1'b1;
                out_lead_nxt = held_lead_r;
                out_cnt_nxt  = held_cnt_r;
                out_last_nxt = 1'b0;
              end
              held_v_nxt    = 1'b1;
              held_lead_nxt = high_r[CB-1];
              held_cnt_nxt  = follow_cur;
              runs_nxt      = runs_r + RunW'(1);
            end
            pend_nxt  = '0;
            low_nxt   = {low_r[CB-2:0], 1'b0};
            high_nxt  = {high_r[CB-2:0], 1'b1};
            guard_nxt = guard_r + GuardW'(1);
          end
        end else if (active && do_mid) begin
          // underflow: count a pending bit and zoom on the middle
          pend_nxt  = pend_inc;
          low_nxt   = {low_q[CB-2:0], 1'b0};
          high_nxt  = {high_q[CB-2:0], 1'b1};
          guard_nxt = guard_r + GuardW'(1);
        end else begin
          // done: the held run is the last one of this symbol
          if (held_v_r) begin
            if (out_free) begin
              out_v_nxt    = 1'b1;
              out_lead_nxt = held_lead_r;
              out_cnt_nxt  = held_cnt_r;
              out_last_nxt = 1'b1;
              held_v_nxt   = 1'b0;
              state_nxt    = S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      low_r    <= '0;
      high_r   <= '1;
      pend_r   <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    prod_r      <= prod_nxt;
    bit_r       <= bit_nxt;
    guard_r     <= guard_nxt;
    runs_r      <= runs_nxt;
    held_lead_r <= held_lead_nxt;
    held_cnt_r  <= held_cnt_nxt;
    out_lead_r  <= out_lead_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.lead_bit     = out_lead_r;
  assign out_ch.follow_count = out_cnt_r;
  assign out_ch.run_last     = out_last_r;

endmodule
`default_nettype wire

@@ design/binary_arithmetic_encoder.sv @@
// Path: a symbol beat passes the front register and the queue before it reaches the core;
//   the core forms range*p, then updates the interval, then renormalizes one shift per cycle
//   while the output register can take its runs. A new symbol is taken only once the core
//   is back in idle; a flush beat is handled straight from idle into the output register.
// Reset: synchronous, active low; low = 0, high = all ones, pending = 0, no clearing pass.
`default_nettype none
module binary_arithmetic_encoder #(
  parameter int CODE_BITS    = bae_pkg::CODE_BITS_DEF,
  parameter int PROB_BITS    = bae_pkg::PROB_BITS_DEF,
  parameter int PENDING_BITS = bae_pkg::PENDING_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bae_in_if.sink    in_ch,
  bae_out_if.source out_ch
);

  logic          push_valid;
  logic          push_ready;
  bae_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  bae_pkg::cmd_t pop_cmd;

  // accept and classify beats
  bae_front #(
    .PROB_BITS(PROB_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouple front from the coder
  bae_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // interval update, renorm and run output
  bae_core #(
    .CODE_BITS    (CODE_BITS),
    .PROB_BITS    (PROB_BITS),
    .PENDING_BITS (PENDING_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ verif/tb_binary_arithmetic_encoder.sv @@
`timescale 1ns / 1ps
module tb_binary_arithmetic_encoder;

  localparam int CW = bae_pkg::CODE_BITS_DEF;
  localparam int PW = bae_pkg::PROB_BITS_DEF;
  localparam int NW = bae_pkg::PENDING_BITS_DEF;
  localparam logic [CW-1:0] HALF = CW'(1) << (CW - 1);
  localparam logic [CW-1:0] QTR = CW'(1) << (CW - 2);
  localparam logic [CW-1:0] Q3_MARK = HALF + QTR;
  localparam logic [63:0] PROB_MASK = (64'd1 << PW) - 64'd1;
  localparam int QUIET_LIMIT = 2000;
  localparam int CHOKE_CYCLES = 400;
  localparam int RAND_BEATS = 131;

  typedef struct {
    logic            bit_value;
    logic [bae_pkg::PROB_W-1:0] prob_zero;
    logic            end_of_stream;
    bit              no_gap;
  } sym_t;

  typedef struct {
    logic              lead_bit;
    logic [bae_pkg::FOLLOW_W-1:0] follow_count;
    logic              run_last;
  } run_t;

  logic clk;
  logic rst_n;

  bae_in_if  sym_if ();
  bae_out_if run_if ();

  binary_arithmetic_encoder #(
    .CODE_BITS    (CW),
    .PROB_BITS    (PW),
    .PENDING_BITS (NW)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (sym_if),
    .out_ch (run_if)
  );

  // stimulus and expected runs
  sym_t symbols_todo[$];
  run_t runs_due[$];

  // encoder state mirror
  logic [CW-1:0] enc_low;
  logic [CW-1:0] enc_high;
  logic [NW-1:0] enc_pending;

  int unsigned n_sym = 0, n_flush = 0, n_runs = 0, n_err = 0;
  int unsigned peak_follow = 0, peak_burst = 0;
  int unsigned tx_gap, tx_calm, rx_hold, rx_calm;
  int unsigned quiet = 0;
  sym_t tx_cur;
  bit choke_go;
  logic rx_choke;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic run_t run_of(logic lead, logic [NW-1:0] cnt);
    run_t r;
    r.lead_bit     = lead;
    r.follow_count = bae_pkg::FOLLOW_W'(cnt);
    r.run_last     = 1'b0;
    return r;
  endfunction

  // work out the runs one accepted beat causes and queue them
  task automatic predict_runs(input sym_t s);
    bae_pkg::op_t op;
    logic [63:0] span;
    logic [63:0] part;
    run_t runs[$];
    int round;
    bit done;
    op = s.end_of_stream ? bae_pkg::OP_FLUSH :
         (s.bit_value ? bae_pkg::OP_ONE : bae_pkg::OP_ZERO);
    span = 64'(enc_high) - 64'(enc_low) + 64'd1;
    part = ((64'(s.prob_zero) & PROB_MASK) * span) >> PW;
    case (op)
      bae_pkg::OP_FLUSH: begin
        if (enc_pending != '1) enc_pending++;
        runs.push_back(run_of(enc_low >= QTR, enc_pending));
      end
      bae_pkg::OP_ONE: enc_low = CW'(64'(enc_low) + part);
      default: enc_high = CW'(64'(enc_low) + part);
    endcase
    if (op != bae_pkg::OP_FLUSH) begin
      done = 1'b0;
      // renormalize: one shift per round
      for (round = 0; round <= CW && !done; round++) begin
        if (enc_high < HALF) begin
          if (runs.size() < bae_pkg::MAX_RUNS) runs.push_back(run_of(1'b0, enc_pending));
          enc_pending = '0;
        end else if (enc_low >= HALF) begin
          enc_low  -= HALF;
          enc_high -= HALF;
          if (runs.size() < bae_pkg::MAX_RUNS) runs.push_back(run_of(1'b1, enc_pending));
          enc_pending = '0;
        end else if (enc_low >= QTR && enc_high < Q3_MARK) begin
          if (enc_pending != '1) enc_pending++;
          enc_low  -= QTR;
          enc_high -= QTR;
        end else begin
          done = 1'b1;
        end
        if (!done) begin
          enc_low  = enc_low << 1;
          enc_high = (enc_high << 1) | CW'(1);
        end
      end
    end
    if (runs.size() > 0) runs[runs.size()-1].run_last = 1'b1;
    if (runs.size() > peak_burst && op != bae_pkg::OP_FLUSH) peak_burst = runs.size();
    foreach (runs[i]) runs_due.push_back(runs[i]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (symbols_todo.size() != 0 || sym_if.valid || runs_due.size() != 0);
  endtask

  function automatic void queue_symbol(logic b, logic [bae_pkg::PROB_W-1:0] p, logic eos);
    symbols_todo.push_back('{b, p, eos, 1'b0});
  endfunction

  // driver: one beat per handshake, random gap after each outside calm stretches
  always @(posedge clk) begin
    sym_t nxt;
    if (!rst_n) begin
      sym_if.valid         <= 1'b0;
      sym_if.bit_value     <= 1'b0;
      sym_if.prob_zero     <= '0;
      sym_if.end_of_stream <= 1'b0;
      tx_gap               <= 0;
      tx_calm              <= 0;
      enc_low     = '0;
      enc_high    = '1;
      enc_pending = '0;
    end else begin
      if (sym_if.valid && sym_if.ready) begin
        predict_runs(tx_cur);
        if (tx_cur.end_of_stream) n_flush++;
        else n_sym++;
      end
      if (!sym_if.valid || sym_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap       <= tx_gap - 1;
          sym_if.valid <= 1'b0;
        end else if (symbols_todo.size() > 0) begin
          nxt = symbols_todo.pop_front();
          tx_cur                <= nxt;
          sym_if.valid          <= 1'b1;
          sym_if.bit_value      <= nxt.bit_value;
          sym_if.prob_zero      <= nxt.prob_zero;
          sym_if.end_of_stream  <= nxt.end_of_stream;
          if (nxt.no_gap || tx_calm > 0) tx_gap <= 0;
          else tx_gap <= $urandom_range(0, 16);
          if (tx_calm > 0) tx_calm <= tx_calm - 1;
          else if ($urandom_range(0, 24) == 0) tx_calm <= $urandom_range(8, 30);
        end else begin
          sym_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each run beat with the oldest expectation
  always @(posedge clk) begin
    run_t want;
    int unsigned hold;
    if (!rst_n) begin
      run_if.ready <= 1'b0;
      rx_hold      <= 0;
      rx_calm      <= 0;
    end else begin
      hold = rx_hold;
      if (run_if.valid && run_if.ready) begin
        n_runs++;
        if (run_if.follow_count > peak_follow) peak_follow = run_if.follow_count;
        if (runs_due.size() == 0) begin
          $error("unexpected run: lead_bit %0b follow_count %0d run_last %0b",
                 run_if.lead_bit, run_if.follow_count, run_if.run_last);
          n_err++;
        end else begin
          want = runs_due.pop_front();
          if (run_if.lead_bit !== want.lead_bit) begin
            $error("lead_bit: expected %0b, got %0b", want.lead_bit, run_if.lead_bit);
            n_err++;
          end
          if (run_if.follow_count !== want.follow_count) begin
            $error("follow_count: expected %0d, got %0d",
                   want.follow_count, run_if.follow_count);
            n_err++;
          end
          if (run_if.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_if.run_last);
            n_err++;
          end
        end
        if (rx_calm > 0) hold = 0;
        else hold = $urandom_range(0, 16);
        if (rx_calm > 0) rx_calm <= rx_calm - 1;
        else if ($urandom_range(0, 24) == 0) rx_calm <= $urandom_range(8, 30);
      end else if (hold > 0) begin
        hold--;
      end
      rx_hold      <= hold;
      run_if.ready <= (hold == 0) && !rx_choke;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    rx_choke = 1'b0;
    wait (choke_go);
    @(posedge clk);
    rx_choke <= 1'b1;
    repeat (CHOKE_CYCLES) @(posedge clk);
    rx_choke <= 1'b0;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (sym_if.valid && sym_if.ready) || (run_if.valid && run_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Stalled: no beat on either channel for %0d cycles, %0d runs compared",
               QUIET_LIMIT, n_runs);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    sym_t s;
    int k;
    choke_go = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both symbols, flushes, collapse to a single point
    queue_symbol(1'b0, 16'h8000, 1'b0);
    queue_symbol(1'b1, 16'h8000, 1'b0);
    queue_symbol(1'b0, 16'h0000, 1'b0);   // interval collapses, long renorm
    queue_symbol(1'b1, 16'hffff, 1'b0);   // tiny top slice
    queue_symbol(1'b0, 16'hffff, 1'b0);
    queue_symbol(1'b1, 16'h0000, 1'b0);   // low unchanged
    queue_symbol(1'b0, 16'h0001, 1'b0);
    queue_symbol(1'b0, 16'h0000, 1'b1);   // flush, fields ignored
    queue_symbol(1'b1, 16'hc000, 1'b0);
    queue_symbol(1'b1, 16'hffff, 1'b1);   // flush with junk fields
    queue_symbol(1'b1, 16'h4000, 1'b0);   // straddle the middle for underflow
    queue_symbol(1'b0, 16'h8000, 1'b0);
    queue_symbol(1'b1, 16'h5555, 1'b0);
    queue_symbol(1'b0, 16'haaaa, 1'b0);
    queue_symbol(1'b1, 16'h7fff, 1'b0);
    queue_symbol(1'b0, 16'h8001, 1'b0);
    queue_symbol(1'b0, 16'h1234, 1'b1);
    queue_symbol(1'b1, 16'hfffe, 1'b0);
    queue_symbol(1'b0, 16'h0000, 1'b0);
    wait_drained();

    // random: mostly symbols drawn to match their probability
    choke_go = 1'b1;
    for (k = 0; k < RAND_BEATS; k++) begin
      s.no_gap = 1'b0;
      s.end_of_stream = 1'b0;
      s.bit_value = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: begin
          s.end_of_stream = 1'b1;
          s.prob_zero = 16'($urandom);
        end
        1, 2, 3: s.prob_zero = $urandom_range(0, 1) ? 16'($urandom_range(0, 2))
                                                   : 16'hffff - 16'($urandom_range(0, 2));
        4, 5, 6: s.prob_zero = 16'($urandom);
        default: begin
          s.prob_zero = 16'($urandom_range(1, 65535));
          s.bit_value = ($urandom_range(0, 65535) >= 32'(s.prob_zero));
        end
      endcase
      symbols_todo.push_back(s);
    end
    wait_drained();
    repeat (64) @(posedge clk);

    $display("Encoded %0d symbols and %0d end-of-stream beats, %0d runs compared",
             n_sym, n_flush, n_runs);
    $display("Largest follow count seen %0d, most runs from one symbol %0d",
             peak_follow, peak_burst);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
